@@ sv/qslerp_pkg.sv @@
`timescale 1ns / 1ps

package qslerp_pkg;

    // field widths
    localparam int QW      = 18;
    localparam int LIM_W   = 17;
    // inner Q2.30 datapath widths
    localparam int D_W     = 32;
    localparam int RAD_W   = 61;
    localparam int S_W     = 31;
    localparam int CV_W    = 34;
    localparam int OM_W    = 32;
    localparam int FB_W    = 31;
    localparam int DIV_W   = 66;
    localparam int QT_W    = 35;
    localparam int W_W     = 36;
    localparam int STEPS   = 30;
    localparam int ROOT_BITS = 31;

    localparam logic [OM_W-1:0] PI_Q30      = 32'd3373259426;
    localparam logic [OM_W-1:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [CV_W-1:0] CORDIC_K    = 34'd652032874;

    // arctangent of 2^-i, Q30
    localparam logic [29:0] ARC_TAB [STEPS] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
    };

    typedef logic signed [CV_W-1:0] t_cv;

    typedef struct packed {
        t_cv x;
        t_cv y;
        t_cv z;
    } t_cordic;

    typedef t_cordic [1:0] t_cordic2;

    typedef struct packed {
        logic [3:0][QW-1:0] qa;
        logic [3:0][QW-1:0] qb;
        logic [FB_W-1:0]    fb;
    } t_side;

    typedef struct packed {
        t_side                  side;
        logic signed [D_W-1:0]  d;
    } t_sq_pass;

    typedef struct packed {
        t_side          side;
        logic [S_W-1:0] s;
        logic           lin;
    } t_ang_pass;

    typedef struct packed {
        t_side      side;
        logic       lin;
        logic [1:0] neg;
        logic [1:0] ovf;
    } t_div_pass;

endpackage

@@ sv/qslerp_sqrt_cell.sv @@
`timescale 1ns / 1ps

// one result bit of the square root per cell
module qslerp_sqrt_cell #(
    parameter int BIT = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [qslerp_pkg::RAD_W-1:0]  i_rem,
    input  logic [qslerp_pkg::S_W-1:0]    i_root,
    input  qslerp_pkg::t_sq_pass          i_pass,
    output logic                          o_vld,
    output logic [qslerp_pkg::RAD_W-1:0]  o_rem,
    output logic [qslerp_pkg::S_W-1:0]    o_root,
    output qslerp_pkg::t_sq_pass          o_pass
);

    localparam int RW = qslerp_pkg::RAD_W;
    localparam int SW = qslerp_pkg::S_W;

    logic [63:0]   rem_ext;
    logic [63:0]   trial;
    logic [63:0]   diff;
    logic          take;
    logic          r_vld;
    logic [RW-1:0] r_rem;
    logic [SW-1:0] r_root;
    qslerp_pkg::t_sq_pass r_pass;

    assign rem_ext = {{(64-RW){1'b0}}, i_rem};
    assign trial   = ({{(64-SW){1'b0}}, i_root} << (BIT + 1)) + (64'd1 << (2 * BIT));
    assign diff    = rem_ext - trial;
    assign take    = rem_ext >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= take ? diff[RW-1:0] : i_rem;
            r_root <= take ? (i_root | ({{(SW-1){1'b0}}, 1'b1} << BIT)) : i_root;
            r_pass <= i_pass;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pass = r_pass;

endmodule

@@ sv/qslerp_vec_cell.sv @@
`timescale 1ns / 1ps

// one vectoring micro-rotation, drives y toward zero
module qslerp_vec_cell #(
    parameter int STEP = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  qslerp_pkg::t_cordic    i_c,
    input  qslerp_pkg::t_ang_pass  i_pass,
    output logic                   o_vld,
    output qslerp_pkg::t_cordic    o_c,
    output qslerp_pkg::t_ang_pass  o_pass
);

    localparam int CW = qslerp_pkg::CV_W;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] arc;
    qslerp_pkg::t_cordic  n_c;
    logic                 r_vld;
    qslerp_pkg::t_cordic  r_c;
    qslerp_pkg::t_ang_pass r_pass;

    assign dx  = $signed(i_c.x) >>> STEP;
    assign dy  = $signed(i_c.y) >>> STEP;
    assign arc = $signed({{(CW-30){1'b0}}, qslerp_pkg::ARC_TAB[STEP]});

    always_comb begin
        if ($signed(i_c.y) > 0) begin
            n_c.x = i_c.x + dy;
            n_c.y = i_c.y - dx;
            n_c.z = i_c.z + arc;
        end else begin
            n_c.x = i_c.x - dy;
            n_c.y = i_c.y + dx;
            n_c.z = i_c.z - arc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c    <= n_c;
            r_pass <= i_pass;
        end
    end

    assign o_vld  = r_vld;
    assign o_c    = r_c;
    assign o_pass = r_pass;

endmodule

@@ sv/qslerp_rot_cell.sv @@
`timescale 1ns / 1ps

// one rotation micro-step for both sine lanes
module qslerp_rot_cell #(
    parameter int STEP = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  qslerp_pkg::t_cordic2   i_c,
    input  qslerp_pkg::t_ang_pass  i_pass,
    output logic                   o_vld,
    output qslerp_pkg::t_cordic2   o_c,
    output qslerp_pkg::t_ang_pass  o_pass
);

    localparam int CW = qslerp_pkg::CV_W;

    logic signed [CW-1:0]  arc;
    qslerp_pkg::t_cordic2  n_c;
    logic                  r_vld;
    qslerp_pkg::t_cordic2  r_c;
    qslerp_pkg::t_ang_pass r_pass;

    assign arc = $signed({{(CW-30){1'b0}}, qslerp_pkg::ARC_TAB[STEP]});

    always_comb begin
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        for (int l = 0; l < 2; l++) begin
            dx = $signed(i_c[l].x) >>> STEP;
            dy = $signed(i_c[l].y) >>> STEP;
            if ($signed(i_c[l].z) >= 0) begin
                n_c[l].x = i_c[l].x - dy;
                n_c[l].y = i_c[l].y + dx;
                n_c[l].z = i_c[l].z - arc;
            end else begin
                n_c[l].x = i_c[l].x + dy;
                n_c[l].y = i_c[l].y - dx;
                n_c[l].z = i_c[l].z + arc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c    <= n_c;
            r_pass <= i_pass;
        end
    end

    assign o_vld  = r_vld;
    assign o_c    = r_c;
    assign o_pass = r_pass;

endmodule

@@ sv/qslerp_div_cell.sv @@
`timescale 1ns / 1ps

// one restoring quotient bit for both weight lanes
module qslerp_div_cell #(
    parameter int BIT = 34
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  logic [1:0][qslerp_pkg::DIV_W-1:0]    i_rem,
    input  logic [1:0][qslerp_pkg::QT_W-1:0]     i_q,
    input  logic [qslerp_pkg::S_W-1:0]           i_s,
    input  qslerp_pkg::t_div_pass                i_pass,
    output logic                                 o_vld,
    output logic [1:0][qslerp_pkg::DIV_W-1:0]    o_rem,
    output logic [1:0][qslerp_pkg::QT_W-1:0]     o_q,
    output logic [qslerp_pkg::S_W-1:0]           o_s,
    output qslerp_pkg::t_div_pass                o_pass
);

    localparam int DW = qslerp_pkg::DIV_W;
    localparam int QW = qslerp_pkg::QT_W;
    localparam int SW = qslerp_pkg::S_W;

    logic [DW-1:0]          sub;
    logic [1:0][DW-1:0]     n_rem;
    logic [1:0][QW-1:0]     n_q;
    logic                   r_vld;
    logic [1:0][DW-1:0]     r_rem;
    logic [1:0][QW-1:0]     r_q;
    logic [SW-1:0]          r_s;
    qslerp_pkg::t_div_pass  r_pass;

    assign sub = {{(DW-SW){1'b0}}, i_s} << BIT;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (i_rem[l] >= sub) begin
                n_rem[l] = i_rem[l] - sub;
                n_q[l]   = i_q[l] | ({{(QW-1){1'b0}}, 1'b1} << BIT);
            end else begin
                n_rem[l] = i_rem[l];
                n_q[l]   = i_q[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_s    <= i_s;
            r_pass <= i_pass;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_q    = r_q;
    assign o_s    = r_s;
    assign o_pass = r_pass;

endmodule

@@ sv/quaternion_slerp_core.sv @@
`timescale 1ns / 1ps

// quaternion slerp, fully pipelined
// - slave channel: one word carries q1, q2 and the blend fraction; a word is
//   taken on every edge where i_s_tvalid and o_s_tready are both high
// - master channel: one word carries the interpolated quaternion, tuser is
//   high when the small-angle linear weights were used
// - config: i_cfg_wr_en writes small_angle_limit (Q1.16), change it only
//   while no word is in flight
// - throughput: one word per cycle, back to back, unless the output buffer stalls
// - pipeline: 31 square-root cells, 30 vectoring cells, 30 sine cells, 35
//   divider cells, plus 7 single stages and the output buffer
// - stall: a two-word output buffer sits at the end of the pipe; the pipe
//   and o_s_tready hold only while the buffer is full and not being read
// - reset: synchronous, clears all valid bits and the buffer, and sets
//   small_angle_limit to 66
module quaternion_slerp_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // q1_x, q1_y, q1_z, q1_w, q2_x, q2_y, q2_z, q2_w (18 each), blend (17), pad
    input  logic [167:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // r_x, r_y, r_z, r_w (18 each)
    output logic [71:0]  o_m_tdata,
    // used_linear
    output logic         o_m_tuser,
    input  logic         i_cfg_wr_en,
    input  logic [16:0]  i_cfg_wr_data
);

    localparam int QW    = qslerp_pkg::QW;
    localparam int CW    = qslerp_pkg::CV_W;
    localparam int SW    = qslerp_pkg::S_W;
    localparam int DW    = qslerp_pkg::DIV_W;
    localparam int QTW   = qslerp_pkg::QT_W;
    localparam int WW    = qslerp_pkg::W_W;
    localparam int RW    = qslerp_pkg::RAD_W;
    localparam int NSTEP = qslerp_pkg::STEPS;
    localparam int NROOT = qslerp_pkg::ROOT_BITS;
    localparam int NDIV  = qslerp_pkg::QT_W;

    // dot product scaling to Q30
    localparam int SH  = 30 - 2 * FRAC_BITS;
    localparam int SHL = (SH >= 0) ? SH : 0;
    localparam int SHR = (SH < 0) ? -SH : 0;
    localparam logic [31:0] ONE_F   = 32'd1 << FRAC_BITS;
    localparam int          SAT     = (FRAC_BITS <= 16) ? (1 << FRAC_BITS) : 131071;
    localparam logic signed [55:0] SAT_P = 56'(SAT);
    localparam logic signed [55:0] SAT_N = -56'(SAT);
    localparam logic signed [47:0] D_HI  = 48'sd1073741824;
    localparam logic signed [47:0] D_LO  = -48'sd1073741824;
    localparam logic [RW-1:0]      RAD_ONE = {1'b1, {(RW-1){1'b0}}};
    localparam logic [QTW-1:0]     W_LIM_Q = {1'b1, {(QTW-1){1'b0}}};
    localparam logic signed [WW-1:0] W_LIM  = $signed({1'b0, W_LIM_Q});
    localparam logic signed [WW-1:0] Q30_ONE_W = 36'sd1073741824;
    localparam logic signed [55:0] HALF_LSB = 56'sd536870912;

    typedef struct packed {
        logic [3:0][QW-1:0] r;
        logic               lin;
    } t_res;

    logic en;

    // ---------------- configuration ----------------
    logic [16:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 17'd66;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // ---------------- stage 1: unpack, blend clamp, four products ----------------
    qslerp_pkg::t_side in_side;
    logic [31:0]       blend_c;
    logic [31:0]       blend_ext;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_side.qa[i] = i_s_tdata[i*QW +: QW];
            in_side.qb[i] = i_s_tdata[(4+i)*QW +: QW];
        end
        blend_ext  = {15'b0, i_s_tdata[144 +: 17]};
        // fraction above one is held at one
        blend_c    = (blend_ext > ONE_F) ? ONE_F : blend_ext;
        in_side.fb = blend_c[30:0] << (30 - FRAC_BITS);
    end

    logic                     r_p1_vld;
    logic signed [35:0]       r_p1_prod [4];
    qslerp_pkg::t_side        r_p1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_p1_prod[i] <= $signed(in_side.qa[i]) * $signed(in_side.qb[i]);
            end
            r_p1_side <= in_side;
        end
    end

    // ---------------- stage 2: sum, scale to Q30, clamp to [-1, 1] ----------------
    logic signed [47:0] dot_sum;
    logic signed [47:0] dot_sh;
    logic signed [31:0] dot_q30;

    always_comb begin
        dot_sum = '0;
        for (int i = 0; i < 4; i++) begin
            dot_sum = dot_sum + {{12{r_p1_prod[i][35]}}, r_p1_prod[i]};
        end
        dot_sh = (dot_sum <<< SHL) >>> SHR;
        if (dot_sh > D_HI) begin
            dot_q30 = D_HI[31:0];
        end else if (dot_sh < D_LO) begin
            dot_q30 = D_LO[31:0];
        end else begin
            dot_q30 = dot_sh[31:0];
        end
    end

    logic               r_p2_vld;
    logic signed [31:0] r_p2_d;
    qslerp_pkg::t_side  r_p2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (en) begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_d    <= dot_q30;
            r_p2_side <= r_p1_side;
        end
    end

    // ---------------- stage 3: d squared ----------------
    logic signed [63:0] d_sq;
    assign d_sq = r_p2_d * r_p2_d;

    logic               r_p3_vld;
    logic [RW-1:0]      r_p3_dd;
    logic signed [31:0] r_p3_d;
    qslerp_pkg::t_side  r_p3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else if (en) begin
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_dd   <= d_sq[RW-1:0];
            r_p3_d    <= r_p2_d;
            r_p3_side <= r_p2_side;
        end
    end

    // ---------------- sine of the angle: sqrt(1 - d*d), one bit per cell ----------------
    logic                 sq_vld  [NROOT+1];
    logic [RW-1:0]        sq_rem  [NROOT+1];
    logic [SW-1:0]        sq_root [NROOT+1];
    qslerp_pkg::t_sq_pass sq_pass [NROOT+1];

    assign sq_vld[0]       = r_p3_vld;
    assign sq_rem[0]       = RAD_ONE - r_p3_dd;
    assign sq_root[0]      = '0;
    assign sq_pass[0].side = r_p3_side;
    assign sq_pass[0].d    = r_p3_d;

    for (genvar g = 0; g < NROOT; g++) begin : g_sqrt
        qslerp_sqrt_cell #(
            .BIT (NROOT - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_vld[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_pass  (sq_pass[g]),
            .o_vld   (sq_vld[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_pass  (sq_pass[g+1])
        );
    end

    // ---------------- angle: vectoring on (d, s) ----------------
    logic [SW-1:0]         s_val;
    logic signed [31:0]    d_val;
    logic                  lin_sel;

    assign s_val = sq_root[NROOT];
    assign d_val = sq_pass[NROOT].d;
    // zero sine always goes linear, even with a zero limit
    assign lin_sel = (s_val == '0) || (s_val < {r_limit, 14'b0});

    logic                   vc_vld  [NSTEP+1];
    qslerp_pkg::t_cordic    vc_c    [NSTEP+1];
    qslerp_pkg::t_ang_pass  vc_pass [NSTEP+1];

    always_comb begin
        // negative d: start a quarter turn ahead
        if (d_val < 0) begin
            vc_c[0].x = {3'b000, s_val};
            vc_c[0].y = -{{2{d_val[31]}}, d_val};
            vc_c[0].z = {2'b00, qslerp_pkg::HALF_PI_Q30};
        end else begin
            vc_c[0].x = {{2{d_val[31]}}, d_val};
            vc_c[0].y = {3'b000, s_val};
            vc_c[0].z = '0;
        end
    end

    assign vc_vld[0]       = sq_vld[NROOT];
    assign vc_pass[0].side = sq_pass[NROOT].side;
    assign vc_pass[0].s    = s_val;
    assign vc_pass[0].lin  = lin_sel;

    for (genvar g = 0; g < NSTEP; g++) begin : g_vec
        qslerp_vec_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vc_vld[g]),
            .i_c     (vc_c[g]),
            .i_pass  (vc_pass[g]),
            .o_vld   (vc_vld[g+1]),
            .o_c     (vc_c[g+1]),
            .o_pass  (vc_pass[g+1])
        );
    end

    // ---------------- stage 4: clamp angle to [0, pi] ----------------
    logic signed [CW-1:0] om_raw;
    logic [31:0]          om_c;

    assign om_raw = vc_c[NSTEP].z;

    always_comb begin
        if (om_raw < 0) begin
            om_c = '0;
        end else if (om_raw > $signed({2'b00, qslerp_pkg::PI_Q30})) begin
            om_c = qslerp_pkg::PI_Q30;
        end else begin
            om_c = om_raw[31:0];
        end
    end

    logic                  r_p4_vld;
    logic [31:0]           r_p4_om;
    qslerp_pkg::t_ang_pass r_p4_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_vld <= 1'b0;
        end else if (en) begin
            r_p4_vld <= vc_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_om   <= om_c;
            r_p4_pass <= vc_pass[NSTEP];
        end
    end

    // ---------------- stage 5: angle times fraction ----------------
    logic [62:0] om_fb;
    assign om_fb = r_p4_om * r_p4_pass.side.fb;

    logic                  r_p5_vld;
    logic [62:0]           r_p5_prod;
    logic [31:0]           r_p5_om;
    qslerp_pkg::t_ang_pass r_p5_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_vld <= 1'b0;
        end else if (en) begin
            r_p5_vld <= r_p4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p5_prod <= om_fb;
            r_p5_om   <= r_p4_om;
            r_p5_pass <= r_p4_pass;
        end
    end

    // ---------------- two sines by rotation ----------------
    function automatic logic [31:0] fold_angle(input logic [31:0] a);
        logic [31:0] r;
        if (a > qslerp_pkg::HALF_PI_Q30) begin
            r = qslerp_pkg::PI_Q30 - a;
        end else begin
            r = a;
        end
        return r;
    endfunction

    logic [31:0] ang2;
    logic [31:0] ang1;

    assign ang2 = r_p5_prod[61:30];
    assign ang1 = r_p5_om - ang2;

    logic                   rt_vld  [NSTEP+1];
    qslerp_pkg::t_cordic2   rt_c    [NSTEP+1];
    qslerp_pkg::t_ang_pass  rt_pass [NSTEP+1];

    // lane 0 weights q1, lane 1 weights q2
    assign rt_c[0][0].x = qslerp_pkg::CORDIC_K;
    assign rt_c[0][0].y = '0;
    assign rt_c[0][0].z = {2'b00, fold_angle(ang1)};
    assign rt_c[0][1].x = qslerp_pkg::CORDIC_K;
    assign rt_c[0][1].y = '0;
    assign rt_c[0][1].z = {2'b00, fold_angle(ang2)};
    assign rt_vld[0]    = r_p5_vld;
    assign rt_pass[0]   = r_p5_pass;

    for (genvar g = 0; g < NSTEP; g++) begin : g_rot
        qslerp_rot_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (rt_vld[g]),
            .i_c     (rt_c[g]),
            .i_pass  (rt_pass[g]),
            .o_vld   (rt_vld[g+1]),
            .o_c     (rt_c[g+1]),
            .o_pass  (rt_pass[g+1])
        );
    end

    // ---------------- sine over s, one quotient bit per cell ----------------
    logic                   dv_vld  [NDIV+1];
    logic [1:0][DW-1:0]     dv_rem  [NDIV+1];
    logic [1:0][QTW-1:0]    dv_q    [NDIV+1];
    logic [SW-1:0]          dv_s    [NDIV+1];
    qslerp_pkg::t_div_pass  dv_pass [NDIV+1];

    always_comb begin
        logic signed [CW-1:0] y;
        logic [CW-1:0]        mag;
        for (int l = 0; l < 2; l++) begin
            y   = rt_c[NSTEP][l].y;
            mag = (y < 0) ? -y : y;
            dv_pass[0].neg[l] = y < 0;
            // quotient of 2^35 or more only ever clamps
            dv_pass[0].ovf[l] = {6'b0, mag} >= {4'b0, rt_pass[NSTEP].s, 5'b0};
            dv_rem[0][l]      = {2'b00, mag, 30'b0};
            dv_q[0][l]        = '0;
        end
    end

    assign dv_vld[0]       = rt_vld[NSTEP];
    assign dv_s[0]         = rt_pass[NSTEP].s;
    assign dv_pass[0].side = rt_pass[NSTEP].side;
    assign dv_pass[0].lin  = rt_pass[NSTEP].lin;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        qslerp_div_cell #(
            .BIT (NDIV - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (dv_vld[g]),
            .i_rem   (dv_rem[g]),
            .i_q     (dv_q[g]),
            .i_s     (dv_s[g]),
            .i_pass  (dv_pass[g]),
            .o_vld   (dv_vld[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_q     (dv_q[g+1]),
            .o_s     (dv_s[g+1]),
            .o_pass  (dv_pass[g+1])
        );
    end

    // ---------------- stage 6: weight select and clamp ----------------
    qslerp_pkg::t_div_pass  dv_out;
    logic signed [WW-1:0]   wt [2];
    logic signed [WW-1:0]   fb_w;

    assign dv_out = dv_pass[NDIV];
    assign fb_w   = $signed({5'b0, dv_out.side.fb});

    always_comb begin
        logic [QTW-1:0] qm;
        for (int l = 0; l < 2; l++) begin
            // spherical weights held at +-16.0
            if (dv_out.ovf[l] || (dv_q[NDIV][l] > W_LIM_Q)) begin
                qm = W_LIM_Q;
            end else begin
                qm = dv_q[NDIV][l];
            end
            wt[l] = dv_out.neg[l] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        end
        if (dv_out.lin) begin
            wt[0] = Q30_ONE_W - fb_w;
            wt[1] = fb_w;
        end
    end

    logic                  r_p6_vld;
    logic signed [WW-1:0]  r_p6_w [2];
    logic [3:0][QW-1:0]    r_p6_qa;
    logic [3:0][QW-1:0]    r_p6_qb;
    logic                  r_p6_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p6_vld <= 1'b0;
        end else if (en) begin
            r_p6_vld <= dv_vld[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p6_w[0] <= wt[0];
            r_p6_w[1] <= wt[1];
            r_p6_qa   <= dv_out.side.qa;
            r_p6_qb   <= dv_out.side.qb;
            r_p6_lin  <= dv_out.lin;
        end
    end

    // ---------------- stage 7: eight weight products ----------------
    logic               r_p7_vld;
    logic signed [53:0] r_p7_ma [4];
    logic signed [53:0] r_p7_mb [4];
    logic               r_p7_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p7_vld <= 1'b0;
        end else if (en) begin
            r_p7_vld <= r_p6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_p7_ma[i] <= r_p6_w[0] * $signed(r_p6_qa[i]);
                r_p7_mb[i] <= r_p6_w[1] * $signed(r_p6_qb[i]);
            end
            r_p7_lin <= r_p6_lin;
        end
    end

    // round, floor shift, saturate
    t_res res;

    always_comb begin
        logic signed [55:0] acc;
        logic signed [55:0] sh;
        for (int i = 0; i < 4; i++) begin
            acc = {{2{r_p7_ma[i][53]}}, r_p7_ma[i]} + {{2{r_p7_mb[i][53]}}, r_p7_mb[i]}
                + HALF_LSB;
            sh  = acc >>> 30;
            if (sh > SAT_P) begin
                res.r[i] = SAT_P[QW-1:0];
            end else if (sh < SAT_N) begin
                res.r[i] = SAT_N[QW-1:0];
            end else begin
                res.r[i] = sh[QW-1:0];
            end
        end
        res.lin = r_p7_lin;
    end

    // ---------------- two-word output buffer ----------------
    t_res       r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign en   = (r_cnt != 2'd2) || i_m_tready;
    assign push = r_p7_vld && en;
    assign pop  = (r_cnt != 2'd0) && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= res;
        end
    end

    assign o_s_tready = en;
    assign o_m_tvalid = r_cnt != 2'd0;
    assign o_m_tdata  = r_buf[r_rd].r;
    assign o_m_tuser  = r_buf[r_rd].lin;

    // ---------------- checks ----------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && (r_cnt == 2'd2)) |-> pop)
        else $error("push into full output buffer");

    a_take_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_p1_vld)
        else $error("accepted word lost at pipe entry");

    a_lin_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p6_vld && r_p6_lin) |-> ((r_p6_w[0] + r_p6_w[1]) == Q30_ONE_W))
        else $error("linear weights do not sum to one");

    a_w_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p6_vld |-> ((r_p6_w[0] <= W_LIM) && (r_p6_w[0] >= -W_LIM)
                   && (r_p6_w[1] <= W_LIM) && (r_p6_w[1] >= -W_LIM)))
        else $error("weight beyond clamp");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int FRAC   = 16;
    localparam int LAT    = 134;
    localparam int N_RAND = 550;
    localparam longint LIMIT_CYC = 400000;
    localparam longint Q_ONE  = 64'sd1 << 30;
    localparam longint Q_PI   = 64'sd3373259426;
    localparam longint Q_HPI  = 64'sd1686629713;
    localparam longint K_GAIN = 64'sd652032874;
    localparam longint W_LIM  = 64'sd1 << 34;
    localparam logic [17:0] P1 = 18'h10000;  // +1.0
    localparam logic [17:0] M1 = 18'h30000;  // -1.0
    localparam logic [17:0] PMAX = 18'h1FFFF;
    localparam logic [17:0] NMIN = 18'h20000;

    typedef struct packed {
        logic [3:0][17:0] q1;
        logic [3:0][17:0] q2;
        logic [16:0]      blend;
    } t_slerp_in;

    typedef struct packed {
        logic [3:0][17:0] r;
        logic             lin;
    } t_slerp_out;

    typedef struct {
        t_slerp_in  word;
        bit         has_exp;
        t_slerp_out exp_val;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [167:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [71:0]  o_m_tdata;
    logic         o_m_tuser;
    logic         i_cfg_wr_en;
    logic [16:0]  i_cfg_wr_data;

    quaternion_slerp_core #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    t_slerp_out  pending_q[$];
    logic [16:0] angle_limit;
    int          fails = 0;
    longint      cycles = 0;
    bit          stall_on = 1'b0;
    string       r_names [4] = '{"r_x", "r_y", "r_z", "r_w"};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor shift, mirrors an arithmetic right shift
    function automatic longint fl_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint arc_of(int i);
        return longint'(qslerp_pkg::ARC_TAB[i]);
    endfunction

    // angle of (x, y), y >= 0, by cordic vectoring
    function automatic longint vec_angle_q30(longint x, longint y);
        longint z, t, dx, dy;
        z = 0;
        if (x < 0) begin
            t = x; x = y; y = -t; z = Q_HPI;
        end
        for (int i = 0; i < qslerp_pkg::STEPS; i++) begin
            dx = fl_shr(x, i); dy = fl_shr(y, i);
            if (y > 0) begin
                x += dy; y -= dx; z += arc_of(i);
            end else begin
                x -= dy; y += dx; z -= arc_of(i);
            end
        end
        return z;
    endfunction

    function automatic longint sine_q30(longint a);
        longint x, y, z, dx, dy;
        x = K_GAIN; y = 0;
        if (a > Q_HPI) a = Q_PI - a;
        z = a;
        for (int i = 0; i < qslerp_pkg::STEPS; i++) begin
            dx = fl_shr(x, i); dy = fl_shr(y, i);
            if (z >= 0) begin
                x -= dy; y += dx; z -= arc_of(i);
            end else begin
                x += dy; y -= dx; z += arc_of(i);
            end
        end
        return y;
    endfunction

    function automatic t_slerp_out predict_slerp(t_slerp_in w, logic [16:0] lim);
        t_slerp_out o;
        longint a[4], b[4], dot, d, s, fb, w1, w2, om, a1, a2, r, bl;
        dot = 0;
        for (int i = 0; i < 4; i++) begin
            a[i] = longint'($signed(w.q1[i]));
            b[i] = longint'($signed(w.q2[i]));
            dot += a[i] * b[i];
        end
        d = clip(fl_shr(dot, 2 * FRAC - 30), -Q_ONE, Q_ONE);
        s = root_floor(longint'(Q_ONE * Q_ONE) - d * d);
        bl = longint'(w.blend);
        if (bl > (64'sd1 << FRAC)) bl = 64'sd1 << FRAC;
        fb = bl << (30 - FRAC);
        o.lin = (s == 0) || (s < (longint'(lim) << 14));
        if (o.lin) begin
            w1 = Q_ONE - fb;
            w2 = fb;
        end else begin
            om = clip(vec_angle_q30(d, s), 0, Q_PI);
            a2 = fl_shr(om * fb, 30);
            a1 = om - a2;
            w1 = clip((sine_q30(a1) * Q_ONE) / s, -W_LIM, W_LIM);
            w2 = clip((sine_q30(a2) * Q_ONE) / s, -W_LIM, W_LIM);
        end
        for (int i = 0; i < 4; i++) begin
            r = fl_shr(w1 * a[i] + w2 * b[i] + (64'sd1 << 29), 30);
            r = clip(r, -(64'sd1 << FRAC), 64'sd1 << FRAC);
            o.r[i] = r[17:0];
        end
        return o;
    endfunction

    function automatic logic [17:0] rand_comp();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0) return 18'($urandom);
        if (k == 1) return $urandom_range(0, 1) ? P1 : M1;
        return 18'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic t_slerp_in rand_word();
        t_slerp_in w;
        int unsigned k;
        k = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
            w.q1[i] = rand_comp();
            // nearby pairs reach the linear fallback
            if (k == 0)
                w.q2[i] = w.q1[i] + 18'($signed($urandom_range(0, 8)) - 4);
            else if (k == 1)
                w.q2[i] = -w.q1[i] + 18'($signed($urandom_range(0, 8)) - 4);
            else
                w.q2[i] = rand_comp();
        end
        w.blend = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        return w;
    endfunction

    // gap on the sender side, valid drops only when the gap is not empty
    task automatic idle_cycles();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (n != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hand one word to the block, store its expectation at acceptance
    task automatic send_word(t_slerp_in w, bit has_exp, t_slerp_out fixed_exp);
        t_slerp_out e;
        if ($urandom_range(0, 2) == 0) idle_cycles();
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {15'd0, w.blend, w.q2[3], w.q2[2], w.q2[1], w.q2[0],
                       w.q1[3], w.q1[2], w.q1[1], w.q1[0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        e = predict_slerp(w, angle_limit);
        if (has_exp && e !== fixed_exp)
            $error("predictor disagrees with table row: exp %h got %h", fixed_exp, e);
        pending_q.push_back(has_exp ? fixed_exp : e);
    endtask

    task automatic drain_and_write(logic [16:0] lim);
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= lim;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        angle_limit = lim;
    endtask

    // receiver: random backpressure, checks each word against the oldest expectation
    always @(posedge i_clk) begin
        t_slerp_out e;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fails++;
                end else begin
                    e = pending_q.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (o_m_tdata[i*18 +: 18] !== e.r[i]) begin
                            $error("%s exp %h got %h", r_names[i], e.r[i],
                                   o_m_tdata[i*18 +: 18]);
                            fails++;
                        end
                    if (o_m_tuser !== e.lin) begin
                        $error("used_linear exp %b got %b", e.lin, o_m_tuser);
                        fails++;
                    end
                end
            end
            // stretches with and without stalls
            if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
            i_m_tready <= stall_on ? ($urandom_range(0, 9) == 0 ? 1'b0
                                      : ($urandom_range(0, 3) != 0))
                                   : 1'b1;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (cycles > LIMIT_CYC) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row rows[$];
        t_dir_row row;
        t_slerp_out none;
        t_slerp_in w;
        none = '0;
        angle_limit = 17'd66;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identical unit quaternions: zero sine, linear weights, blend half
        row.word = '{q1: '{0, 0, 0, P1}, q2: '{0, 0, 0, P1}, blend: 17'h08000};
        row.has_exp = 1; row.exp_val = '{r: '{0, 0, 0, P1}, lin: 1'b1}; rows.push_back(row);
        // all zero: dot zero, spherical, output zero
        row.word = '0;
        row.has_exp = 1; row.exp_val = '{r: '0, lin: 1'b0}; rows.push_back(row);
        // opposite quaternions, blend zero, linear
        row.word = '{q1: '{0, 0, 0, P1}, q2: '{0, 0, 0, M1}, blend: 17'h0};
        row.has_exp = 1; row.exp_val = '{r: '{0, 0, 0, P1}, lin: 1'b1}; rows.push_back(row);
        // blend above one is clamped
        row.word = '{q1: '{0, 0, 0, P1}, q2: '{0, 0, 0, P1}, blend: 17'h1FFFF};
        row.has_exp = 1; row.exp_val = '{r: '{0, 0, 0, P1}, lin: 1'b1}; rows.push_back(row);
        row.has_exp = 0;
        // orthogonal pair, blend 0, half, 1
        row.word = '{q1: '{0, 0, 0, P1}, q2: '{0, 0, P1, 0}, blend: 17'h0}; rows.push_back(row);
        row.word.blend = 17'h08000; rows.push_back(row);
        row.word.blend = 17'h10000; rows.push_back(row);
        // out-of-range patterns, saturation and weight clamp
        row.word = '{q1: '{PMAX, PMAX, PMAX, PMAX}, q2: '{NMIN, NMIN, NMIN, NMIN},
                     blend: 17'h04000}; rows.push_back(row);
        row.word = '{q1: '{PMAX, NMIN, PMAX, NMIN}, q2: '{PMAX, NMIN, PMAX, NMIN},
                     blend: 17'h0C000}; rows.push_back(row);
        row.word = '{q1: '{18'h0B505, 0, 0, 18'h0B505}, q2: '{0, 18'h0B505, 0, 18'h0B505},
                     blend: 17'h05555}; rows.push_back(row);
        // nearly parallel: small sine near the threshold
        row.word = '{q1: '{0, 0, 0, P1}, q2: '{18'd3, 0, 0, P1}, blend: 17'h08000};
        rows.push_back(row);
        row.word = '{q1: '{0, 0, 0, P1}, q2: '{18'd60, 0, 0, 18'h0FFFF}, blend: 17'h02000};
        rows.push_back(row);
        row.word = '{q1: '{M1, 0, 0, 0}, q2: '{P1, 18'd40, 0, 0}, blend: 17'h0E000};
        rows.push_back(row);

        foreach (rows[i]) send_word(rows[i].word, rows[i].has_exp, rows[i].exp_val);

        // limit settings, extremes included; the sender waits out each drain
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: drain_and_write(17'd0);
                1: drain_and_write(17'h1FFFF);
                2: drain_and_write(17'h10000);
                3: drain_and_write(17'($urandom_range(1, 4000)));
                default: drain_and_write(17'd66);
            endcase
            for (int n = 0; n < N_RAND / 5; n++) begin
                w = rand_word();
                send_word(w, 0, none);
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 20) @(posedge i_clk);
        if (fails == 0 && pending_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
